### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file cdda_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define CDDA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cdda assertion failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define CDDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cdda assertion failed");

`endif

### hw/rtl/cdda_pkg.sv
// Types, constants, microprogram and calendar helpers for the date day adder.
package cdda_pkg;

    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned MON_W     = 4;
    localparam int unsigned DAY_W     = 5;
    localparam int unsigned DELTA_W   = 16;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned UPC_W     = 4;
    localparam int unsigned WY_W      = 18;
    localparam int unsigned WD_W      = 17;
    localparam int unsigned PROD_W    = 28;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [YEAR_W-1:0] C_MAX_YEAR   = 14'd9999;
    localparam logic [YEAR_W-1:0] C_RESET_YEAR = 14'd1900;

    // reciprocals: 5243 / 2^19 is exact for y / 100 over 14 bits,
    // 5462 / 2^16 overshoots y / 12 by at most one
    localparam logic [12:0] C_RCP100 = 13'd5243;
    localparam logic [12:0] C_RCP12  = 13'd5462;

    localparam logic [OP_W-1:0] OP_LOAD       = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD_YEARS  = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD_MONTHS = 2'd2;
    localparam logic [OP_W-1:0] OP_ADD_DAYS   = 2'd3;

    localparam logic [MON_W-1:0] M_JAN = 4'd1;
    localparam logic [MON_W-1:0] M_FEB = 4'd2;
    localparam logic [MON_W-1:0] M_APR = 4'd4;
    localparam logic [MON_W-1:0] M_JUN = 4'd6;
    localparam logic [MON_W-1:0] M_SEP = 4'd9;
    localparam logic [MON_W-1:0] M_NOV = 4'd11;
    localparam logic [MON_W-1:0] M_DEC = 4'd12;

    typedef enum logic [3:0] {
        A_NONE,
        A_LOAD,
        A_MUL100,
        A_MOD100,
        A_NSTEP,
        A_ADDY,
        A_MSET,
        A_MUL12,
        A_DIV12,
        A_DAYSET,
        A_COMMIT,
        A_FAIL
    } t_act;

    typedef enum logic [1:0] {
        C_ALWAYS,
        C_YBAD,
        C_NORM
    } t_cond;

    typedef struct packed {
        t_act             act;
        t_cond            cond;
        logic             last;
        logic [UPC_W-1:0] ta;
        logic [UPC_W-1:0] tb;
    } t_uword;

    typedef struct packed {
        logic ybad;
        logic in_month;
    } t_stat;

    localparam logic [UPC_W-1:0] U_LOAD   = 4'd0;
    localparam logic [UPC_W-1:0] U_CHK    = 4'd1;
    localparam logic [UPC_W-1:0] U_MUL100 = 4'd2;
    localparam logic [UPC_W-1:0] U_MOD100 = 4'd3;
    localparam logic [UPC_W-1:0] U_NSTEP  = 4'd4;
    localparam logic [UPC_W-1:0] U_ADDY   = 4'd5;
    localparam logic [UPC_W-1:0] U_MSET   = 4'd6;
    localparam logic [UPC_W-1:0] U_MUL12  = 4'd7;
    localparam logic [UPC_W-1:0] U_DIV12  = 4'd8;
    localparam logic [UPC_W-1:0] U_YCHK   = 4'd9;
    localparam logic [UPC_W-1:0] U_DAYSET = 4'd10;
    localparam logic [UPC_W-1:0] U_COMMIT = 4'd11;
    localparam logic [UPC_W-1:0] U_FAIL   = 4'd12;

    function automatic t_uword mk_uw(input t_act act, input t_cond cond, input logic last,
                                     input logic [UPC_W-1:0] ta,
                                     input logic [UPC_W-1:0] tb);
        t_uword w;
        w.act  = act;
        w.cond = cond;
        w.last = last;
        w.ta   = ta;
        w.tb   = tb;
        return w;
    endfunction

    // microprogram ROM
    function automatic t_uword uprog(input logic [UPC_W-1:0] a);
        t_uword w;
        unique case (a)
            U_LOAD:   w = mk_uw(A_LOAD,   C_ALWAYS, 1'b0, U_CHK,    U_CHK);
            U_CHK:    w = mk_uw(A_NONE,   C_YBAD,   1'b0, U_FAIL,   U_MUL100);
            U_MUL100: w = mk_uw(A_MUL100, C_ALWAYS, 1'b0, U_MOD100, U_MOD100);
            U_MOD100: w = mk_uw(A_MOD100, C_ALWAYS, 1'b0, U_NSTEP,  U_NSTEP);
            U_NSTEP:  w = mk_uw(A_NSTEP,  C_NORM,   1'b0, U_COMMIT, U_NSTEP);
            U_ADDY:   w = mk_uw(A_ADDY,   C_ALWAYS, 1'b0, U_YCHK,   U_YCHK);
            U_MSET:   w = mk_uw(A_MSET,   C_ALWAYS, 1'b0, U_MUL12,  U_MUL12);
            U_MUL12:  w = mk_uw(A_MUL12,  C_ALWAYS, 1'b0, U_DIV12,  U_DIV12);
            U_DIV12:  w = mk_uw(A_DIV12,  C_ALWAYS, 1'b0, U_YCHK,   U_YCHK);
            U_YCHK:   w = mk_uw(A_NONE,   C_YBAD,   1'b0, U_FAIL,   U_COMMIT);
            U_DAYSET: w = mk_uw(A_DAYSET, C_ALWAYS, 1'b0, U_CHK,    U_CHK);
            U_COMMIT: w = mk_uw(A_COMMIT, C_ALWAYS, 1'b1, U_LOAD,   U_LOAD);
            default:  w = mk_uw(A_FAIL,   C_ALWAYS, 1'b1, U_LOAD,   U_LOAD);
        endcase
        return w;
    endfunction

    // entry point of each operation
    function automatic logic [UPC_W-1:0] dispatch(input logic [OP_W-1:0] op);
        logic [UPC_W-1:0] a;
        unique case (op)
            OP_LOAD:       a = U_LOAD;
            OP_ADD_YEARS:  a = U_ADDY;
            OP_ADD_MONTHS: a = U_MSET;
            default:       a = U_DAYSET;
        endcase
        return a;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            M_FEB:                      len = leap ? 5'd29 : 5'd28;
            M_APR, M_JUN, M_SEP, M_NOV: len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### hw/rtl/cdda_useq.sv
// Microcode sequencer: step counter, control ROM and branch logic.
module cdda_useq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cdda_pkg::OP_W-1:0] i_op,
    input  cdda_pkg::t_stat           i_stat,
    input  logic                      i_hold,
    output cdda_pkg::t_act            o_act,
    output logic                      o_busy
);
    import cdda_pkg::*;

    logic             r_busy, n_busy;
    logic [UPC_W-1:0] r_upc, n_upc;
    logic [UPC_W-1:0] w_branch;
    logic             w_fire;
    t_uword           w_uw;

    assign w_uw = uprog(r_upc);

    // the final step waits for room in the output register
    assign w_fire = r_busy && !(w_uw.last && i_hold);

    always_comb begin
        unique case (w_uw.cond)
            C_ALWAYS: w_branch = w_uw.ta;
            C_YBAD:   w_branch = i_stat.ybad ? w_uw.ta : w_uw.tb;
            C_NORM: begin
                if (i_stat.ybad) begin
                    w_branch = U_FAIL;
                end else if (i_stat.in_month) begin
                    w_branch = w_uw.ta;
                end else begin
                    w_branch = w_uw.tb;
                end
            end
            default:  w_branch = w_uw.ta;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_upc  = r_upc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_upc  = dispatch(i_op);
            end
        end else if (w_fire) begin
            if (w_uw.last) begin
                n_busy = 1'b0;
            end else begin
                n_upc = w_branch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= U_LOAD;
        end else begin
            r_busy <= n_busy;
            r_upc  <= n_upc;
        end
    end

    assign o_act  = w_fire ? w_uw.act : A_NONE;
    assign o_busy = r_busy;

endmodule

### hw/rtl/calendar_date_day_adder.sv
// Gregorian date register with load and signed add of years, months or days.
// Add years runs ADDY, YCHK and COMMIT; add months runs MSET, MUL12, DIV12, YCHK and COMMIT;
// load and add days run the NSTEP loop, one month per pass, until the day fits its month.
// One word at a time; for load and add days the month stepping loop sets the rate.
// Synchronous active-low reset: date 1900-01-01, sequencer idle, no result held.
module calendar_date_day_adder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // load_year[13:0], load_month[17:14], load_day[22:18], delta[38:23], zero[39]
    input  logic [cdda_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op[1:0]
    input  logic [cdda_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // year[13:0], month[17:14], day[22:18], range_error[23]
    output logic [cdda_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import cdda_pkg::*;

    localparam logic signed [WY_W-1:0] L_WY_MAX = signed'(WY_W'(C_MAX_YEAR));

    logic                      w_accept, w_busy, w_hold, w_leap, w_neg;
    logic [DAY_W-1:0]          w_len_cur, w_len_prev;
    logic [DELTA_W-1:0]        w_x;
    t_stat                     w_stat;
    t_act                      w_act;

    logic [YEAR_W-1:0]         r_ly;
    logic [MON_W-1:0]          r_lm;
    logic [DAY_W-1:0]          r_ld;
    logic signed [DELTA_W-1:0] r_delta;

    logic [YEAR_W-1:0]         r_cy, n_cy;
    logic [MON_W-1:0]          r_cm, n_cm;
    logic [DAY_W-1:0]          r_cd, n_cd;
    logic signed [WY_W-1:0]    r_wy, n_wy;
    logic [MON_W-1:0]          r_wm, n_wm;
    logic signed [WD_W-1:0]    r_wd, n_wd;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic [6:0]                r_ym100, n_ym100;
    logic [1:0]                r_yc4, n_yc4;
    logic                      r_o_valid, n_o_valid;
    logic [M_TDATA_W-1:0]      r_o_data, n_o_data;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !w_busy;
    assign w_hold        = r_o_valid && !m_axis_tready;

    // leap from year mod 100 and century mod 4
    assign w_leap = ((r_ym100 != 7'd0) && (r_ym100[1:0] == 2'd0))
                  || ((r_ym100 == 7'd0) && (r_yc4 == 2'd0));
    assign w_len_cur  = month_len(r_wm, w_leap);
    assign w_len_prev = (r_wm == M_JAN) ? 5'd31 : month_len(r_wm - 4'd1, w_leap);

    assign w_stat.ybad     = r_wy[WY_W-1] || (r_wy > L_WY_MAX);
    assign w_stat.in_month = !r_wd[WD_W-1] && (r_wd != '0)
                             && (r_wd <= signed'(WD_W'(w_len_cur)));

    // month offset folded to a non-negative dividend: ~v = -v - 1
    assign w_neg = r_wd[WD_W-1];
    assign w_x   = w_neg ? ~r_wd[DELTA_W-1:0] : r_wd[DELTA_W-1:0];

    cdda_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_op    (s_axis_tuser),
        .i_stat  (w_stat),
        .i_hold  (w_hold),
        .o_act   (w_act),
        .o_busy  (w_busy)
    );

    always_comb begin
        logic [7:0]              q100;
        logic [YEAR_W-1:0]       rem100;
        logic [11:0]             q12e;
        logic [11:0]             q12;
        logic signed [17:0]      re12;
        logic [3:0]              r12;
        logic [3:0]              rf;
        logic signed [WY_W-1:0]  qf;

        q100   = r_prod[26:19];
        rem100 = r_wy[YEAR_W-1:0] - YEAR_W'(q100) * 14'd100;
        q12e   = r_prod[27:16];
        re12   = $signed({2'b00, w_x}) - $signed(18'(q12e) * 18'd12);
        if (re12[17]) begin
            q12 = q12e - 12'd1;
            r12 = 4'(re12 + 18'sd12);
        end else begin
            q12 = q12e;
            r12 = 4'(re12);
        end
        qf = w_neg ? ~$signed(WY_W'(q12)) : $signed(WY_W'(q12));
        rf = w_neg ? (4'd11 - r12) : r12;

        n_cy      = r_cy;
        n_cm      = r_cm;
        n_cd      = r_cd;
        n_wy      = r_wy;
        n_wm      = r_wm;
        n_wd      = r_wd;
        n_prod    = r_prod;
        n_ym100   = r_ym100;
        n_yc4     = r_yc4;
        n_o_data  = r_o_data;
        n_o_valid = r_o_valid;
        if (r_o_valid && m_axis_tready) begin
            n_o_valid = 1'b0;
        end

        unique case (w_act)
            A_LOAD: begin
                n_wd = $signed(WD_W'(r_ld));
                if (r_lm == 4'd0) begin
                    n_wy = $signed(WY_W'(r_ly)) - 18'sd1;
                    n_wm = M_DEC;
                end else if (r_lm > M_DEC) begin
                    n_wy = $signed(WY_W'(r_ly)) + 18'sd1;
                    n_wm = r_lm - M_DEC;
                end else begin
                    n_wy = $signed(WY_W'(r_ly));
                    n_wm = r_lm;
                end
            end
            A_MUL100: n_prod = PROD_W'(r_wy[YEAR_W-1:0]) * PROD_W'(C_RCP100);
            A_MOD100: begin
                n_ym100 = rem100[6:0];
                n_yc4   = q100[1:0];
            end
            A_NSTEP: begin
                if (!w_stat.in_month) begin
                    if (r_wd[WD_W-1] || (r_wd == '0)) begin
                        // borrow the length of the month before
                        n_wd = r_wd + $signed(WD_W'(w_len_prev));
                        if (r_wm == M_JAN) begin
                            n_wm = M_DEC;
                            n_wy = r_wy - 18'sd1;
                            if (r_ym100 == 7'd0) begin
                                n_ym100 = 7'd99;
                                n_yc4   = r_yc4 - 2'd1;
                            end else begin
                                n_ym100 = r_ym100 - 7'd1;
                            end
                        end else begin
                            n_wm = r_wm - 4'd1;
                        end
                    end else begin
                        n_wd = r_wd - $signed(WD_W'(w_len_cur));
                        if (r_wm == M_DEC) begin
                            n_wm = M_JAN;
                            n_wy = r_wy + 18'sd1;
                            if (r_ym100 == 7'd99) begin
                                n_ym100 = 7'd0;
                                n_yc4   = r_yc4 + 2'd1;
                            end else begin
                                n_ym100 = r_ym100 + 7'd1;
                            end
                        end else begin
                            n_wm = r_wm + 4'd1;
                        end
                    end
                end
            end
            A_ADDY: begin
                n_wy = $signed(WY_W'(r_cy)) + WY_W'(r_delta);
                n_wm = r_cm;
                n_wd = $signed(WD_W'(r_cd));
            end
            A_MSET:  n_wd = $signed(WD_W'(r_cm)) - 17'sd1 + WD_W'(r_delta);
            A_MUL12: n_prod = PROD_W'(w_x) * PROD_W'(C_RCP12);
            A_DIV12: begin
                n_wy = $signed(WY_W'(r_cy)) + qf;
                n_wm = rf + 4'd1;
                n_wd = $signed(WD_W'(r_cd));
            end
            A_DAYSET: begin
                n_wy = $signed(WY_W'(r_cy));
                n_wm = r_cm;
                n_wd = $signed(WD_W'(r_cd)) + WD_W'(r_delta);
            end
            A_COMMIT: begin
                n_cy      = r_wy[YEAR_W-1:0];
                n_cm      = r_wm;
                n_cd      = r_wd[DAY_W-1:0];
                n_o_data  = {1'b0, r_wd[DAY_W-1:0], r_wm, r_wy[YEAR_W-1:0]};
                n_o_valid = 1'b1;
            end
            A_FAIL: begin
                // hold the date, report it with the error flag
                n_o_data  = {1'b1, r_cd, r_cm, r_cy};
                n_o_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cy      <= C_RESET_YEAR;
            r_cm      <= M_JAN;
            r_cd      <= 5'd1;
            r_o_valid <= 1'b0;
        end else begin
            r_cy      <= n_cy;
            r_cm      <= n_cm;
            r_cd      <= n_cd;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ly    <= s_axis_tdata[13:0];
            r_lm    <= s_axis_tdata[17:14];
            r_ld    <= s_axis_tdata[22:18];
            r_delta <= $signed(s_axis_tdata[38:23]);
        end
        r_wy     <= n_wy;
        r_wm     <= n_wm;
        r_wd     <= n_wd;
        r_prod   <= n_prod;
        r_ym100  <= n_ym100;
        r_yc4    <= n_yc4;
        r_o_data <= n_o_data;
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

endmodule

### hw/rtl/cdda_chk.sv
// Port-level checker for the date day adder, bound to the top level.
`include "assert_macros.svh"

module cdda_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [cdda_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input logic [cdda_pkg::OP_W-1:0]        s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [cdda_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import cdda_pkg::*;

    logic w_in_word;
    logic w_date_ok;

    assign w_in_word = s_axis_tvalid && s_axis_tready && (s_axis_tuser == s_axis_tuser)
                       && (s_axis_tdata == s_axis_tdata);
    assign w_date_ok = (m_axis_tdata[17:14] >= M_JAN) && (m_axis_tdata[17:14] <= M_DEC)
                       && (m_axis_tdata[22:18] != 5'd0)
                       && (m_axis_tdata[13:0] <= C_MAX_YEAR);

    // one word in flight: an accepted word closes the input side
    `CDDA_ASSERT_NEXT(a_busy_after_accept, w_in_word, !s_axis_tready)

    `CDDA_ASSERT_NEXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // every reported date, held or new, has month 1 to 12, a nonzero day and a year of at most 9999
    `CDDA_ASSERT_SAME(a_date_range, m_axis_tvalid, w_date_ok)

endmodule

bind calendar_date_day_adder cdda_chk u_cdda_chk (.*);
